/* rtl/core/rse_pkg.sv */
// Package for the Reed-Solomon systematic encoder.
// Holds the beat payload types, the register map and the controller command type.
// Depends on nothing; every other file of the block uses it.
package rse_pkg;

    localparam int FIELD_W = 8;
    localparam int CNT_W = 5;
    localparam int IDX_W = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_POLY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PARITY_COUNT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROOTS_LOW = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROOTS_HIGH = 4'd3;

    localparam logic [FIELD_W-1:0] FIELD_POLY_RESET = 8'd29;
    localparam logic [CNT_W-1:0] PARITY_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [FIELD_W-1:0] data_symbol;
        logic               final_symbol;
    } in_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0] code_symbol;
        logic               is_parity;
        logic               block_end;
    } out_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0]    field_poly;
        logic [CNT_W-1:0]      parity_count;
        logic [CFG_DATA_W-1:0] roots_low;
        logic [CFG_DATA_W-1:0] roots_high;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic             build;
        logic             absorb;
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] top_idx;
        logic [IDX_W-1:0] root_idx;
    } ctrl_cmd_t;

endpackage

/* rtl/core/rse_cfg_regs.sv */
// Configuration register file of the Reed-Solomon encoder.
// Takes writes from the configuration channel; uses rse_pkg.
module rse_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rse_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rse_pkg::CFG_DATA_W-1:0]       cfg_data,
    output rse_pkg::cfg_t                        cfg
);

    rse_pkg::cfg_t cfg_reg;
    rse_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rse_pkg::REG_FIELD_POLY:
                    cfg_next.field_poly = cfg_data[rse_pkg::FIELD_W-1:0];
                rse_pkg::REG_PARITY_COUNT:
                    cfg_next.parity_count = cfg_data[rse_pkg::CNT_W-1:0];
                rse_pkg::REG_ROOTS_LOW:
                    cfg_next.roots_low = cfg_data;
                rse_pkg::REG_ROOTS_HIGH:
                    cfg_next.roots_high = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_poly <= rse_pkg::FIELD_POLY_RESET;
            cfg_reg.parity_count <= rse_pkg::PARITY_COUNT_RESET;
            cfg_reg.roots_low <= '0;
            cfg_reg.roots_high <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/rse_ctrl.sv */
// Controller state machine of the Reed-Solomon encoder.
// Sequences generator build, message absorption and parity output; uses rse_pkg.
module rse_ctrl #(
    parameter int MAX_PARITY = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          final_symbol,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic [rse_pkg::CNT_W-1:0]     parity_count,
    output rse_pkg::ctrl_cmd_t            cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_BUILD  = 4'b0010,
        S_DATA   = 4'b0100,
        S_PARITY = 4'b1000
    } state_t;

    localparam logic [rse_pkg::CNT_W-1:0] MAX_P = rse_pkg::CNT_W'(MAX_PARITY);

    state_t                      state_reg, state_next;
    logic [rse_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rse_pkg::CNT_W-1:0]   act_p_reg, act_p_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        slot_free;
    logic [rse_pkg::CNT_W-1:0]   top_pos;
    logic [rse_pkg::CNT_W-1:0]   clamped_p;

    assign slot_free = !out_valid_reg || out_ready;
    assign top_pos = act_p_reg - rse_pkg::CNT_W'(1);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        if (parity_count == '0)
            clamped_p = rse_pkg::CNT_W'(1);
        else if (parity_count > MAX_P)
            clamped_p = MAX_P;
        else
            clamped_p = parity_count;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        act_p_next = act_p_reg;
        in_ready = 1'b0;
        cmd = '0;
        cmd.top_idx = top_pos[rse_pkg::IDX_W-1:0];
        cmd.root_idx = cnt_reg[rse_pkg::IDX_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    act_p_next = clamped_p;
                    cnt_next = '0;
                    state_next = S_BUILD;
                end
            end
            S_BUILD:
            begin
                cmd.build = 1'b1;
                if (cnt_reg == top_pos)
                begin
                    cnt_next = '0;
                    state_next = S_DATA;
                end
                else
                begin
                    cnt_next = cnt_reg + rse_pkg::CNT_W'(1);
                end
            end
            S_DATA:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free)
                begin
                    cmd.absorb = 1'b1;
                    if (final_symbol)
                    begin
                        cnt_next = '0;
                        state_next = S_PARITY;
                    end
                end
            end
            S_PARITY:
            begin
                if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (cnt_reg == top_pos);
                    cnt_next = cnt_reg + rse_pkg::CNT_W'(1);
                    if (cnt_reg == top_pos)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.absorb || cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            act_p_reg <= MAX_P;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            act_p_reg <= act_p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_ready_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_DATA))
        else $error("input ready outside the data phase");

    a_parity_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PARITY || state_reg == S_BUILD) |-> (cnt_reg < act_p_reg))
        else $error("sequence counter passed the parity count");

    a_active_p_range: assert property (@(posedge clk) disable iff (!rst_n)
        (act_p_reg != '0) && (act_p_reg <= MAX_P))
        else $error("latched parity count out of range");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == S_IDLE) && out_valid)
        else $error("final parity beat did not close the codeword");

endmodule

/* rtl/core/rse_datapath.sv */
// Datapath of the Reed-Solomon encoder: generator and remainder registers,
// shared GF multipliers and the output register. Uses rse_pkg.
module rse_datapath #(
    parameter int SYMBOL_BITS = 8,
    parameter int MAX_PARITY = 16
) (
    input  logic                              clk,
    input  rse_pkg::ctrl_cmd_t                cmd,
    input  rse_pkg::cfg_t                     cfg,
    input  logic [rse_pkg::FIELD_W-1:0]       data_symbol,
    output rse_pkg::out_beat_t                out_data
);

    localparam int SB = SYMBOL_BITS;
    localparam int MP = MAX_PARITY;
    localparam int IW = (MP > 1) ? $clog2(MP) : 1;

    logic [SB-1:0]  rem_reg [MP];
    logic [SB-1:0]  gen_reg [MP];
    logic [SB-1:0]  prod    [MP];
    logic [SB-1:0]  poly_reg;
    logic [SB-1:0]  top_sym;
    logic [SB-1:0]  feedback;
    logic [SB-1:0]  root;
    logic [SB-1:0]  mul_a;
    logic [2*rse_pkg::CFG_DATA_W-1:0] roots_all;
    logic [IW-1:0]  top;
    rse_pkg::out_beat_t out_reg;

    function automatic logic [SB-1:0] gf_mul(input logic [SB-1:0] a,
                                             input logic [SB-1:0] b,
                                             input logic [SB-1:0] poly);
        logic [SB:0] r;
        r = '0;
        for (int i = SB - 1; i >= 0; i--)
        begin
            r = {r[SB-1:0], 1'b0};
            if (r[SB])
                r = r ^ {1'b1, poly};
            if (b[i])
                r = r ^ {1'b0, a};
        end
        return r[SB-1:0];
    endfunction

    assign top = cmd.top_idx[IW-1:0];
    assign top_sym = rem_reg[top];
    assign feedback = data_symbol[SB-1:0] ^ top_sym;
    assign roots_all = {cfg.roots_high, cfg.roots_low};
    assign root = roots_all[{cmd.root_idx, 3'b000} +: SB];
    assign mul_a = cmd.build ? root : feedback;
    assign out_data = out_reg;

    always_comb
    begin
        for (int j = 0; j < MP; j++)
            prod[j] = gf_mul(mul_a, gen_reg[j], poly_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            poly_reg <= cfg.field_poly[SB-1:0];
            for (int j = 0; j < MP; j++)
            begin
                rem_reg[j] <= '0;
                gen_reg[j] <= (j == 0) ? SB'(1) : '0;
            end
        end
        if (cmd.build)
        begin
            gen_reg[0] <= prod[0];
            for (int j = 1; j < MP; j++)
                gen_reg[j] <= gen_reg[j-1] ^ prod[j];
        end
        if (cmd.absorb)
        begin
            rem_reg[0] <= prod[0];
            for (int j = 1; j < MP; j++)
                rem_reg[j] <= rem_reg[j-1] ^ prod[j];
            out_reg.code_symbol <= (rse_pkg::FIELD_W)'(data_symbol[SB-1:0]);
            out_reg.is_parity <= 1'b0;
            out_reg.block_end <= 1'b0;
        end
        if (cmd.emit)
        begin
            rem_reg[0] <= '0;
            for (int j = 1; j < MP; j++)
                rem_reg[j] <= rem_reg[j-1];
            out_reg.code_symbol <= (rse_pkg::FIELD_W)'(top_sym);
            out_reg.is_parity <= 1'b1;
            out_reg.block_end <= cmd.last;
        end
    end

endmodule

/* rtl/core/reed_solomon_systematic_encoder.sv */
// Top level of the systematic Reed-Solomon encoder over GF(2^SYMBOL_BITS).
// Instantiates rse_cfg_regs, rse_ctrl and rse_datapath; uses rse_pkg.
//
// Usage. Message symbols enter on in_valid/in_ready, highest degree first,
// with final_symbol set on the last one. Every message beat is passed to
// out_valid/out_ready in the cycle after it is accepted, and after the final
// beat the p parity symbols follow, degree p-1 first, block_end on the last.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only between codewords: parity count and
// field polynomial are latched, and the roots read, when a message starts.
// Timing. When the first beat of a message is offered, the block first
// latches the settings and then forms the generator, one root per cycle
// through the shared GF multipliers, before it takes that beat. Message
// beats then go at one per cycle, and parity beats at one per cycle after
// the final beat, as long as the receiver does not stall. A stalled receiver
// holds the output register; input is taken only while that register is
// free or being emptied in the same cycle.
// Reset clears the controller and restores the register reset values; no
// clearing pass is needed.
module reed_solomon_systematic_encoder #(
    parameter int SYMBOL_BITS = 8,
    parameter int MAX_PARITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rse_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rse_pkg::out_beat_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rse_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rse_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rse_pkg::cfg_t      cfg;
    rse_pkg::ctrl_cmd_t cmd;

    rse_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rse_ctrl #(
        .MAX_PARITY (MAX_PARITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .final_symbol (in_data.final_symbol),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parity_count (cfg.parity_count),
        .cmd          (cmd)
    );

    rse_datapath #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .MAX_PARITY  (MAX_PARITY)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .cfg         (cfg),
        .data_symbol (in_data.data_symbol),
        .out_data    (out_data)
    );

endmodule
